// ===== hw/rtl/isd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_pkg: shared types and constants for interval_set_difference
// Word layouts of both channels, the internal command word and the codes
// used between the front queue and the back walker.
// ----------------------------------------------------------------------------
package isd_pkg;

   // table capacity (at least 1)
   localparam int MAX_EXCLUSIONS = 32;

   localparam int POS_W  = 32;
   localparam int CUR_W  = POS_W + 1;
   localparam int EXCL_W = 2 * POS_W;
   localparam int IDX_W  = (MAX_EXCLUSIONS > 1) ? $clog2(MAX_EXCLUSIONS) : 1;
   localparam int CNT_W  = $clog2(MAX_EXCLUSIONS + 1);

   // request codes as they arrive on the input channel
   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_LOAD   = 2'd1,
      REQ_TRIM   = 2'd2,
      REQ_UNUSED = 2'd3
   } req_code_type;

   // classified commands handed to the back end
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_TRIM  = 2'd2,
      CMD_VOID  = 2'd3
   } cmd_code_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_WALK  = 2'd1,
      ST_TAIL  = 2'd2,
      ST_FINAL = 2'd3
   } back_state_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [POS_W-1:0] span_start;
      logic [POS_W-1:0] span_stop;
   } req_word_type;

   typedef struct packed {
      logic [POS_W-1:0] frag_start;
      logic [POS_W-1:0] frag_stop;
      logic             frag_present;
      logic             last;
      logic             table_overflowed;
   } rsp_word_type;

   typedef struct packed {
      cmd_code_type     cmd;
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] stop;
   } cmd_word_type;

endpackage

// ===== hw/rtl/interval_set_difference.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_difference: trim ranges against a table of exclusions
// Request words push in on req_ (clear table, load exclusion, trim range);
// result words pop out on rsp_, one per remaining fragment of a trim, in
// ascending order, the final one with last set. A fully excluded or
// inverted range gives a single word with frag_present low.
// Clear and load give no result. A trim walks the table entries in the back
// end (at most MAX_EXCLUSIONS, one per cycle through the table RAM read
// port while the output does not stall), after it has passed through the
// two-entry command queue.
// Reset empties both queues and the table, and clears the overflow flag.
// When the receiver stalls, the walker holds one fragment back and one in
// the output register, then stops; the command queue keeps taking requests
// until it is full, and full then holds the sender.
// ----------------------------------------------------------------------------
module interval_set_difference (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  isd_pkg::req_word_type req_word,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output isd_pkg::rsp_word_type rsp_word
);

   logic                  cmd_empty;
   logic                  cmd_pop;
   isd_pkg::cmd_word_type cmd_word;

   // intake and classification
   isd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_word (req_word),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .cmd_word (cmd_word)
   );

   // table and walker
   isd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd_pop  (cmd_pop),
      .cmd_word (cmd_word),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_word (rsp_word)
   );

endmodule

// ===== hw/rtl/isd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_ram: generic single write, single read RAM
// One write port and one read port with registered read data; the read
// register holds its value while no read is issued.
// ----------------------------------------------------------------------------
module isd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/isd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_front: request intake and classification
// Accepts request words, drops those that do nothing (unused code, inverted
// exclusion), marks inverted ranges as void and queues the rest in a
// two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module isd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  isd_pkg::req_word_type req_word,
   output logic                 cmd_empty,
   input  logic                 cmd_pop,
   output isd_pkg::cmd_word_type cmd_word
);

   isd_pkg::cmd_word_type slot_ff [2];
   logic                  wr_ptr_ff;
   logic                  rd_ptr_ff;
   logic [1:0]            fill_ff;
   logic [1:0]            fill_in;
   logic                  accept;
   logic                  keep;
   logic                  do_push;
   logic                  do_pop;
   isd_pkg::cmd_word_type cls_word;

   assign accept = req_push && !req_full;

   // classify the incoming word
   always_comb begin
      keep           = 1'b0;
      cls_word.cmd   = isd_pkg::CMD_CLEAR;
      cls_word.start = req_word.span_start;
      cls_word.stop  = req_word.span_stop;
      unique case (isd_pkg::req_code_type'(req_word.req_type))
         isd_pkg::REQ_CLEAR: begin
            keep = 1'b1;
         end
         isd_pkg::REQ_LOAD: begin
            keep         = req_word.span_start <= req_word.span_stop;
            cls_word.cmd = isd_pkg::CMD_LOAD;
         end
         isd_pkg::REQ_TRIM: begin
            keep         = 1'b1;
            cls_word.cmd = (req_word.span_start <= req_word.span_stop) ?
                           isd_pkg::CMD_TRIM : isd_pkg::CMD_VOID;
         end
         isd_pkg::REQ_UNUSED: begin
            keep = 1'b0;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign do_push = accept && keep;
   assign do_pop  = cmd_pop && !cmd_empty;
   assign fill_in = fill_ff + {1'b0, do_push} - {1'b0, do_pop};

   // advance queue pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
   end

   // hold queued command words
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= cls_word;
      end
   end

   assign req_full  = fill_ff == 2'd2;
   assign cmd_empty = fill_ff == 2'd0;
   assign cmd_word  = slot_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/isd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_back: exclusion table and range walker
// Owns the exclusion table, executes clear and load commands, and walks the
// table one entry a cycle for each trim while the output does not stall,
// holding one fragment back so that the final one can carry the last mark.
// ----------------------------------------------------------------------------
module isd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   output logic                  cmd_pop,
   input  isd_pkg::cmd_word_type cmd_word,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output isd_pkg::rsp_word_type rsp_word
);

   isd_pkg::back_state_type state_ff, state_in;
   logic [isd_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      overflow_ff, overflow_in;
   logic [isd_pkg::CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [isd_pkg::CUR_W-1:0] cursor_ff, cursor_in;
   logic [isd_pkg::POS_W-1:0] stop_ff, stop_in;
   logic                      pend_vld_ff, pend_vld_in;
   logic [isd_pkg::POS_W-1:0] pend_start_ff, pend_start_in;
   logic [isd_pkg::POS_W-1:0] pend_stop_ff, pend_stop_in;
   logic                      out_vld_ff, out_vld_in;
   isd_pkg::rsp_word_type     out_ff, out_in;

   logic                       wr_en;
   logic                       rd_en;
   logic [isd_pkg::IDX_W-1:0]  rd_addr;
   logic [isd_pkg::EXCL_W-1:0] rd_data;

   logic [isd_pkg::CUR_W-1:0] es_x;
   logic [isd_pkg::CUR_W-1:0] ee_x;
   logic [isd_pkg::CUR_W-1:0] rs_x;
   logic                      past_end;
   logic                      hit;
   logic                      gap;
   logic                      out_ready;
   logic                      emit_req;
   logic [isd_pkg::POS_W-1:0] emit_start;
   logic [isd_pkg::POS_W-1:0] emit_stop;
   logic                      stall;
   logic                      push_out;
   isd_pkg::rsp_word_type     push_word;

   // exclusion table: start in the upper half, stop in the lower
   isd_ram #(
      .WIDTH(isd_pkg::EXCL_W),
      .DEPTH(isd_pkg::MAX_EXCLUSIONS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[isd_pkg::IDX_W-1:0]),
      .wr_data({cmd_word.start, cmd_word.stop}),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // compare the current entry against cursor and range end
   assign es_x      = {1'b0, rd_data[isd_pkg::EXCL_W-1:isd_pkg::POS_W]};
   assign ee_x      = {1'b0, rd_data[isd_pkg::POS_W-1:0]};
   assign rs_x      = {1'b0, stop_ff};
   assign past_end  = cursor_ff > rs_x;
   assign hit       = !(ee_x < cursor_ff || es_x > rs_x);
   assign gap       = es_x > cursor_ff;
   assign out_ready = !out_vld_ff || rsp_pop;

   // fragment produced this cycle, if any
   always_comb begin
      emit_req   = 1'b0;
      emit_start = cursor_ff[isd_pkg::POS_W-1:0];
      emit_stop  = stop_ff;
      unique case (state_ff)
         isd_pkg::ST_WALK: begin
            emit_req  = !past_end && hit && gap;
            emit_stop = rd_data[isd_pkg::EXCL_W-1:isd_pkg::POS_W] - 1'b1;
         end
         isd_pkg::ST_TAIL: begin
            emit_req = !past_end;
         end
         isd_pkg::ST_IDLE, isd_pkg::ST_FINAL: begin
            emit_req = 1'b0;
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase
   end

   assign stall = emit_req && pend_vld_ff && !out_ready;

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      rd_idx_in     = rd_idx_ff;
      cursor_in     = cursor_ff;
      stop_in       = stop_ff;
      pend_vld_in   = pend_vld_ff;
      pend_start_in = pend_start_ff;
      pend_stop_in  = pend_stop_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[isd_pkg::IDX_W-1:0];
      push_out      = 1'b0;
      push_word     = '0;

      // retire the held fragment and keep the new one back
      if (emit_req && !stall) begin
         if (pend_vld_ff) begin
            push_out                   = 1'b1;
            push_word.frag_start       = pend_start_ff;
            push_word.frag_stop        = pend_stop_ff;
            push_word.frag_present     = 1'b1;
            push_word.last             = 1'b0;
            push_word.table_overflowed = overflow_ff;
         end
         pend_vld_in   = 1'b1;
         pend_start_in = emit_start;
         pend_stop_in  = emit_stop;
      end

      unique case (state_ff)
         isd_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               unique case (cmd_word.cmd)
                  isd_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  isd_pkg::CMD_LOAD: begin
                     if (count_ff >= isd_pkg::CNT_W'(isd_pkg::MAX_EXCLUSIONS)) begin
                        overflow_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  isd_pkg::CMD_TRIM: begin
                     cursor_in   = {1'b0, cmd_word.start};
                     stop_in     = cmd_word.stop;
                     pend_vld_in = 1'b0;
                     if (count_ff != '0) begin
                        rd_en     = 1'b1;
                        rd_addr   = '0;
                        rd_idx_in = isd_pkg::CNT_W'(1);
                        state_in  = isd_pkg::ST_WALK;
                     end else begin
                        state_in = isd_pkg::ST_TAIL;
                     end
                  end
                  isd_pkg::CMD_VOID: begin
                     pend_vld_in = 1'b0;
                     state_in    = isd_pkg::ST_FINAL;
                  end
                  default: begin
                     state_in = isd_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         isd_pkg::ST_WALK: begin
            if (past_end) begin
               state_in = isd_pkg::ST_TAIL;
            end else if (!stall) begin
               if (hit) begin
                  cursor_in = ee_x + 1'b1;
               end
               if (rd_idx_ff < count_ff) begin
                  rd_en     = 1'b1;
                  rd_idx_in = rd_idx_ff + 1'b1;
               end else begin
                  state_in = isd_pkg::ST_TAIL;
               end
            end
         end
         isd_pkg::ST_TAIL: begin
            if (!stall) begin
               state_in = isd_pkg::ST_FINAL;
            end
         end
         isd_pkg::ST_FINAL: begin
            // close the range: held fragment with last, or the empty marker
            if (out_ready) begin
               push_out                   = 1'b1;
               push_word.frag_start       = pend_vld_ff ? pend_start_ff : '0;
               push_word.frag_stop        = pend_vld_ff ? pend_stop_ff : '0;
               push_word.frag_present     = pend_vld_ff;
               push_word.last             = 1'b1;
               push_word.table_overflowed = overflow_ff;
               pend_vld_in                = 1'b0;
               state_in                   = isd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = isd_pkg::ST_IDLE;
         end
      endcase

      // output register
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (push_out) begin
         out_vld_in = 1'b1;
         out_in     = push_word;
      end else if (rsp_pop) begin
         out_vld_in = 1'b0;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      cursor_ff     <= cursor_in;
      stop_ff       <= stop_in;
      pend_start_ff <= pend_start_in;
      pend_stop_ff  <= pend_stop_in;
      out_ff        <= out_in;
   end

   assign rsp_empty = !out_vld_ff;
   assign rsp_word  = out_ff;

endmodule

// ===== hw/rtl/isd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isd_checker: port-level checks for interval_set_difference
// Watches the top level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module isd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input isd_pkg::rsp_word_type rsp_word
);

   // both queues come out of reset empty
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a waiting result word holds until popped
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_word))
      else $error("result word changed while waiting");

   // the empty-range marker is always a lone, zeroed, final word
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_word.frag_present |->
         rsp_word.last && rsp_word.frag_start == '0 && rsp_word.frag_stop == '0)
      else $error("malformed empty-range word");

   // a present fragment is never inverted
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_word.frag_present |-> rsp_word.frag_start <= rsp_word.frag_stop)
      else $error("inverted fragment");

   // the overflow flag is sticky on the result side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && rsp_word.table_overflowed ##1 !rsp_empty |->
         rsp_word.table_overflowed)
      else $error("overflow flag dropped");

endmodule

bind interval_set_difference isd_checker u_checker (.*);
